/* src/insertion_sorter_with_shift_count_core_defines.svh */
// assertion macros for the insertion sorter
`ifndef INSERTION_SORTER_WITH_SHIFT_COUNT_CORE_DEFINES_SVH
`define INSERTION_SORTER_WITH_SHIFT_COUNT_CORE_DEFINES_SVH

// same-cycle implication, reset disables the check
`define ISS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables the check
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/iss_pkg.sv */
// shared types and constants of the insertion sorter
package iss_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int VAL_W  = 20;
	localparam int POS_W  = 10;
	localparam int OCNT_W = 11;
	localparam int TOT_W  = 19;
	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] element;
		logic             valid_res;
		logic [CNT_W-1:0] count;
		logic [TOT_W-1:0] total;
		logic             dropped;
	} res_t;

endpackage

/* src/insertion_sorter_with_shift_count_core.sv */
// top level of the insertion sorter with running shift count
//
// Input channel in_valid/in_ready carries operation, value and position;
// output channel out_valid/out_ready returns one result per transaction.
// An insert walks the sorted store from the top down through one ram read
// port and one compare unit, moving one greater element up per cycle until
// it meets one not greater than the new value or reaches the bottom; when
// the store is full the insert is dropped without a walk.
// A valid read goes through the registered ram read; a read past the count,
// a clear or the reserved code finish straight from the idle state.
// The block takes a new transaction only when the sequencer is idle and the
// output register is empty or being drained in that cycle, so a stalled
// receiver holds the result and stops input until it is taken.
// Reset clears the count, the shift total and the handshake state; the
// store itself is not cleared, entries above the count are never read.
module insertion_sorter_with_shift_count_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         operation,
	input  logic [iss_pkg::VAL_W-1:0]          value,
	input  logic [iss_pkg::POS_W-1:0]          position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [iss_pkg::VAL_W-1:0]          element,
	output logic                               valid_res,
	output logic [iss_pkg::OCNT_W-1:0]         element_count,
	output logic [iss_pkg::TOT_W-1:0]          shift_total,
	output logic                               dropped
);
	import iss_pkg::*;

	`include "insertion_sorter_with_shift_count_core_defines.svh"

	logic  seq_idle;
	logic  start;
	res_t  res;
	logic  out_valid_q;
	logic [VAL_W-1:0]  element_q;
	logic              valid_res_q;
	logic [CNT_W-1:0]  count_q;
	logic [TOT_W-1:0]  total_q;
	logic              dropped_q;

	assign in_ready = seq_idle && (!out_valid_q || out_ready);
	assign start    = in_valid && in_ready;

	iss_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.value    (value),
		.position (position),
		.idle     (seq_idle),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			element_q   <= res.element;
			valid_res_q <= res.valid_res;
			count_q     <= res.count;
			total_q     <= res.total;
			dropped_q   <= res.dropped;
		end
	end

	assign out_valid     = out_valid_q;
	assign element       = element_q;
	assign valid_res     = valid_res_q;
	assign element_count = OCNT_W'(count_q);
	assign shift_total   = total_q;
	assign dropped       = dropped_q;

	`ISS_ASSERT_NOW(a_no_overwrite, res.done, !out_valid_q || out_ready, "result overwrote a pending one")
	`ISS_ASSERT_NOW(a_drop_full, out_valid && dropped, count_q == CNT_W'(DEPTH) && !valid_res, "drop while store not full")
	`ISS_ASSERT_NOW(a_read_nonempty, out_valid && valid_res, count_q != '0 && !dropped, "valid read from empty store")
	`ISS_ASSERT_NEXT(a_read_busy, start && operation == OP_READ && !res.done, !in_ready && !out_valid, "read did not hold the sequencer")

endmodule

/* src/iss_ram.sv */
// simple dual-port ram with registered read data
module iss_ram #(
	parameter int DATA_W = 20,
	parameter int DEPTH_P = 1024,
	parameter int ADDR_W = $clog2(DEPTH_P)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH_P];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/iss_seq.sv */
// sequencer: shift-down insertion walk, reads, clear, counters
module iss_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                operation,
	input  logic [iss_pkg::VAL_W-1:0] value,
	input  logic [iss_pkg::POS_W-1:0] position,
	output logic                      idle,
	output iss_pkg::res_t             res
);
	import iss_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [TOT_W-1:0] total_q, total_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [VAL_W-1:0] value_q;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [VAL_W-1:0]  wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [VAL_W-1:0]  rd_data;
	logic              gt;
	logic [CNT_W-1:0]  k_m1;
	logic [CNT_W-1:0]  k_m2;
	op_t               op;

	iss_ram #(
		.DATA_W (VAL_W),
		.DEPTH_P(DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// single compare unit
	assign gt   = rd_data > value_q;
	assign op   = op_t'(operation);
	assign k_m1 = k_q - CNT_W'(1);
	assign k_m2 = k_q - CNT_W'(2);
	assign idle = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			total_q <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d;
		if (start) begin
			value_q <= value;
		end
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		total_d       = total_q;
		k_d           = k_q;
		wr_en         = 1'b0;
		wr_addr       = k_q[ADDR_W-1:0];
		wr_data       = value_q;
		rd_en         = 1'b0;
		rd_addr       = k_m1[ADDR_W-1:0];
		res           = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op)
						OP_INSERT: begin
							if (count_q == CNT_W'(DEPTH)) begin
								res.done    = 1'b1;
								res.dropped = 1'b1;
							end else if (count_q == '0) begin
								k_d     = '0;
								state_d = ST_PLACE;
							end else begin
								rd_en   = 1'b1;
								rd_addr = ADDR_W'(count_q - CNT_W'(1));
								k_d     = count_q;
								state_d = ST_SHIFT;
							end
						end
						OP_READ: begin
							if (32'(position) < 32'(count_q)) begin
								rd_en   = 1'b1;
								rd_addr = ADDR_W'(position);
								state_d = ST_READ;
							end else begin
								res.done = 1'b1;
							end
						end
						OP_CLEAR: begin
							count_d  = '0;
							total_d  = '0;
							res.done = 1'b1;
						end
						default: begin
							res.done = 1'b1;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				if (gt) begin
					wr_en   = 1'b1;
					wr_data = rd_data;
					total_d = (total_q == TOT_MAX) ? total_q : total_q + TOT_W'(1);
					k_d     = k_m1;
					if (k_q == CNT_W'(1)) begin
						state_d = ST_PLACE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = k_m2[ADDR_W-1:0];
					end
				end else begin
					wr_en    = 1'b1;
					count_d  = count_q + CNT_W'(1);
					res.done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PLACE: begin
				wr_en    = 1'b1;
				count_d  = count_q + CNT_W'(1);
				res.done = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_READ: begin
				res.done      = 1'b1;
				res.element   = rd_data;
				res.valid_res = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res.count = count_d;
		res.total = total_d;
	end

endmodule
